// ===== hdl/sspq_pkg.sv =====
// ----------------------------------------------------------------------------
// sspq_pkg: shared types and codes for the stable sorted priority queue
// Holds the slot record, the per-cell control bundle and the result codes.
// ----------------------------------------------------------------------------
package sspq_pkg;

    // Default number of queue slots
    localparam int DEPTH_DEFAULT = 16;

    // Field widths
    localparam int PRIO_W   = 8;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;

    // Operation codes (s_tuser)
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // One stored queue entry
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic  insert;   // insert that will be stored
        logic  remove;   // remove from a non-empty queue
        slot_t item;     // entry being inserted
    } cell_ctrl_t;

endpackage

// ===== hdl/stable_sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top: bounded min-first priority queue
// Sorted shift-register queue built from a row of compare-and-shift cells.
//
// Usage:
//   Input stream s_*: s_tuser selects insert or remove, s_tdata carries the
//   task handle and its priority. Every transfer gives exactly one result
//   on the output stream m_*: a status code, the removed entry (zero when
//   nothing is removed) and a flag that the queue is now empty.
//   Inserts go behind every entry of equal or lower priority value, so
//   equal priorities leave in arrival order; removes return the head.
//   The result is registered and appears in the cycle after the input transfer.
//   Throughput: one item per cycle while m_tready stays high; every cell compares against the new
//   priority in parallel and shifts in the same cycle.
//   The result sits in an output register; a new item is taken in the
//   cycle that register is emptied, so a stalled receiver holds the input
//   side ready low until m_tready returns.
//   Reset empties the queue (fill count to zero) and drops any result.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top #(
    parameter int DEPTH = sspq_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] task_handle, [23:16] priority_req
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] out_handle, [23:16] out_priority
    output logic [2:0]  m_tuser    // [1:0] status, [2] queue_empty
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [CW-1:0]                      cnt_reg;
    logic [CW-1:0]                      cnt_next;
    logic                               out_valid_reg;
    logic [sspq_pkg::STATUS_W-1:0]      status_reg;
    logic [sspq_pkg::STATUS_W-1:0]      status_next;
    sspq_pkg::slot_t                    res_reg;
    sspq_pkg::slot_t                    res_next;
    logic                               empty_reg;

    logic                               accept;
    logic                               op;
    logic                               full;
    logic                               is_empty;
    sspq_pkg::cell_ctrl_t               ctrl;
    sspq_pkg::slot_t                    cell_data [DEPTH];
    logic                               cell_after [DEPTH];

    // Input handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = s_tuser[0];
    assign full     = (cnt_reg == CNT_FULL);
    assign is_empty = (cnt_reg == '0);

    // Control broadcast to the cells
    always_comb
    begin
        ctrl.insert      = accept && (op == sspq_pkg::OP_INSERT) && !full;
        ctrl.remove      = accept && (op == sspq_pkg::OP_REMOVE) && !is_empty;
        ctrl.item.handle = s_tdata[15:0];
        ctrl.item.prio   = s_tdata[23:16];
    end

    // Row of cells, slot 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic            occ;
        logic            l_after;
        sspq_pkg::slot_t l_data;
        sspq_pkg::slot_t r_data;

        assign occ = (cnt_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign l_after = 1'b0;
            assign l_data  = ctrl.item;
        end
        else
        begin : g_body
            assign l_after = cell_after[i-1];
            assign l_data  = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_data = cell_data[i];
        end
        else
        begin : g_mid
            assign r_data = cell_data[i+1];
        end

        sspq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ),
            .left_after (l_after),
            .left_data  (l_data),
            .right_data (r_data),
            .after      (cell_after[i]),
            .data       (cell_data[i])
        );
    end

    // Fill count and result
    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = sspq_pkg::STATUS_OK;
        res_next    = '0;
        priority if (op == sspq_pkg::OP_INSERT)
        begin
            if (full)
                status_next = sspq_pkg::STATUS_FULL;
            else
                cnt_next = cnt_reg + CW'(1);
        end
        else
        begin
            if (is_empty)
                status_next = sspq_pkg::STATUS_EMPTY;
            else
            begin
                cnt_next = cnt_reg - CW'(1);
                res_next = cell_data[0];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            res_reg    <= res_next;
            empty_reg  <= (cnt_next == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.prio, res_reg.handle};
    assign m_tuser  = {empty_reg, status_reg};

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("fill count above depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == sspq_pkg::OP_INSERT) && full
        |=> status_reg == sspq_pkg::STATUS_FULL && cnt_reg == CNT_FULL)
        else $error("insert into full queue not dropped");

    a_remove_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == sspq_pkg::OP_REMOVE) && !is_empty
        |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("remove did not shrink queue");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> empty_reg == (cnt_reg == '0))
        else $error("queue_empty disagrees with fill count");

endmodule

// ===== hdl/sspq_cell.sv =====
// ----------------------------------------------------------------------------
// sspq_cell: one slot of the sorted shift-register queue
// Compares its entry against the incoming priority and either holds,
// takes the new entry, takes its left neighbor (insert) or its right
// neighbor (remove).
// ----------------------------------------------------------------------------
module sspq_cell (
    input  logic                clk,
    input  sspq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,    // slot lies below the fill count
    input  logic                left_after,  // left neighbor stays ahead of new item
    input  sspq_pkg::slot_t     left_data,
    input  sspq_pkg::slot_t     right_data,
    output logic                after,       // this slot stays ahead of new item
    output sspq_pkg::slot_t     data
);

    sspq_pkg::slot_t data_reg;
    sspq_pkg::slot_t data_next;

    // Equal priority stays ahead, which keeps arrival order
    assign after = occupied && (data_reg.prio <= ctrl.item.prio);
    assign data  = data_reg;

    // Next slot contents
    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.insert)
        begin
            priority if (after)
                data_next = data_reg;
            else if (left_after)
                data_next = ctrl.item;
            else
                data_next = left_data;
        end
        else if (ctrl.remove)
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
